// File: hdl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants
// Sizes, sentinels, payload structs and mode codes for the shortest-path core.
// ----------------------------------------------------------------------------
package dsp_pkg;
  localparam int MaxNodes  = 64;
  localparam int MaxEdges  = 256;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int EdgeW     = $clog2(MaxEdges);
  localparam int LinkW     = EdgeW + 1;       // extra bit marks end of list
  localparam int CountW    = 7;
  localparam int DistW     = 24;
  localparam int WeightW   = 16;

  localparam logic [LinkW-1:0] NoEdge = LinkW'(MaxEdges);
  localparam logic signed [DistW-1:0] DistMax = 24'sh7FFFFF;
  localparam logic signed [DistW-1:0] DistMin = 24'sh800000;

  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeRun   = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic [5:0]                edge_from;
    logic [5:0]                edge_to;
    logic signed [WeightW-1:0] edge_weight;
    logic [5:0]                source_node;
  } in_item_t;

  typedef struct packed {
    logic [5:0]              node_index;
    logic signed [DistW-1:0] distance;
    logic                    reachable;
    logic                    edges_dropped;
    logic                    last;
  } out_item_t;
endpackage

// File: hdl/dsp_in_if.sv
// ----------------------------------------------------------------------------
// dsp_in_if: valid/ready channel for input items
// Carries one edge, run or clear item per handshake.
// ----------------------------------------------------------------------------
interface dsp_in_if;
  import dsp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/dsp_out_if.sv
// ----------------------------------------------------------------------------
// dsp_out_if: valid/ready channel for result items
// Carries one per-node result per handshake.
// ----------------------------------------------------------------------------
interface dsp_out_if;
  import dsp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/dsp_cfg_if.sv
// ----------------------------------------------------------------------------
// dsp_cfg_if: configuration write channel
// Carries the node count register write data.
// ----------------------------------------------------------------------------
interface dsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/dag_shortest_path_core.sv
// Flow: an edge item holds the input through S_ADDW and S_ADD, a clear item through the
//   list head sweep. A run holds it through DFS ordering, relaxation and the output of
//   one result per node in use, and result stalls prolong it.
// Items are taken one at a time, the next accepted once the previous one is done; a result
//   is loaded only once the previous one is taken. Reset is synchronous and then sweeps the
//   list heads, during which no item is accepted; config writes are taken at any time.
// ----------------------------------------------------------------------------
// dag_shortest_path_core: single-source shortest paths over a DAG
// Stores edges in per-node lists, orders nodes by DFS and relaxes in order.
// ----------------------------------------------------------------------------
module dag_shortest_path_core (
  input  logic      clk,
  input  logic      rst_n,
  dsp_in_if.sink    in_ch,
  dsp_out_if.source out_ch,
  dsp_cfg_if.sink   cfg_ch
);
  import dsp_pkg::*;

  // state codes
  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ADD    = 5'd2;
  localparam logic [4:0] S_DSTART = 5'd3;
  localparam logic [4:0] S_DPUSH  = 5'd4;
  localparam logic [4:0] S_DTOP   = 5'd5;
  localparam logic [4:0] S_DTOPW  = 5'd6;
  localparam logic [4:0] S_DEDGE  = 5'd7;
  localparam logic [4:0] S_DEDGEW = 5'd8;
  localparam logic [4:0] S_DNEXT  = 5'd9;
  localparam logic [4:0] S_RINIT  = 5'd10;
  localparam logic [4:0] S_RPOP   = 5'd11;
  localparam logic [4:0] S_RPOPW  = 5'd12;
  localparam logic [4:0] S_RHEAD  = 5'd13;
  localparam logic [4:0] S_REDGE  = 5'd14;
  localparam logic [4:0] S_REDGEW = 5'd15;
  localparam logic [4:0] S_RCMP   = 5'd16;
  localparam logic [4:0] S_OREAD  = 5'd17;
  localparam logic [4:0] S_OWAIT  = 5'd18;
  localparam logic [4:0] S_OSEND  = 5'd19;
  localparam logic [4:0] S_ADDW   = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;

  // memories
  logic [NodeW-1:0]          tgt_mem  [MaxEdges];
  logic signed [WeightW-1:0] cost_mem [MaxEdges];
  logic [LinkW-1:0]          next_mem [MaxEdges];
  logic [LinkW-1:0]          head_mem [MaxNodes];
  logic [LinkW-1:0]          tail_mem [MaxNodes];
  logic [NodeW-1:0]          ord_mem  [MaxNodes];
  logic [NodeW-1:0]          snode_mem[MaxNodes];
  logic [LinkW-1:0]          sedge_mem[MaxNodes];
  logic signed [DistW-1:0]   dist_mem [MaxNodes];

  logic [4:0]              st_r;
  logic [CountW-1:0]       ncfg_r;
  logic [CountW-1:0]       n_r;
  logic [LinkW-1:0]        stored_r;
  logic                    drop_r;
  logic [MaxNodes-1:0]     vis_r, reach_r;
  in_item_t                item_r;
  logic [CountW-1:0]       cnt_r;      // start node / init / output index
  logic [CountW-1:0]       depth_r;
  logic [CountW-1:0]       fill_r;
  logic [NodeW-1:0]        u_r, v_r;
  logic [LinkW-1:0]        e_r;
  logic signed [DistW-1:0] du_r;
  logic signed [WeightW-1:0] w_r;
  out_item_t               out_r;
  logic                    ovalid_r;

  // registered read data
  logic [NodeW-1:0]          tgt_q;
  logic signed [WeightW-1:0] cost_q;
  logic [LinkW-1:0]          next_q, head_q, tail_q, sedge_q;
  logic [NodeW-1:0]          ord_q, snode_q;
  logic signed [DistW-1:0]   dist_q;

  // read addresses
  logic [EdgeW-1:0] ea;
  logic [NodeW-1:0] ha, sa, oa, da;

  // effective count: clamp node_count to 1..MaxNodes
  logic [CountW-1:0] n_eff;
  always_comb begin
    if (ncfg_r == '0) n_eff = CountW'(1);
    else if (ncfg_r > CountW'(MaxNodes)) n_eff = CountW'(MaxNodes);
    else n_eff = ncfg_r;
  end

  // saturated candidate distance
  logic signed [DistW:0] sum_w;
  logic signed [DistW-1:0] cand;
  always_comb begin
    sum_w = (DistW+1)'(du_r) + (DistW+1)'(w_r);
    if (sum_w > (DistW+1)'(DistMax)) cand = DistMax;
    else if (sum_w < (DistW+1)'(DistMin)) cand = DistMin;
    else cand = sum_w[DistW-1:0];
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = out_r;

  // read address selection
  always_comb begin
    ea = e_r[EdgeW-1:0];
    ha = u_r;
    sa = NodeW'(depth_r - CountW'(1));
    oa = NodeW'(fill_r - CountW'(1));
    da = (st_r == S_OREAD) ? NodeW'(cnt_r) : ((st_r == S_OWAIT) ? v_r : u_r);
  end

  // synchronous reads
  always_ff @(posedge clk) begin
    tgt_q   <= tgt_mem[ea];
    cost_q  <= cost_mem[ea];
    next_q  <= next_mem[ea];
    head_q  <= head_mem[ha];
    tail_q  <= tail_mem[ha];
    snode_q <= snode_mem[sa];
    sedge_q <= sedge_mem[sa];
    ord_q   <= ord_mem[oa];
    dist_q  <= dist_mem[da];
  end

  // main sequencer and memory writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_INIT;
      ncfg_r   <= CountW'(MaxNodes);
      stored_r <= '0;
      drop_r   <= 1'b0;
      vis_r    <= '0;
      reach_r  <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) ncfg_r <= cfg_ch.data;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        // sweep list heads empty
        S_INIT: begin
          head_mem[NodeW'(cnt_r)] <= NoEdge;
          cnt_r <= cnt_r + CountW'(1);
          if (cnt_r == CountW'(MaxNodes - 1)) begin
            cnt_r <= '0;
            st_r  <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r <= in_ch.data;
            n_r    <= n_eff;
            u_r    <= in_ch.data.edge_from;
            case (in_ch.data.mode)
              ModeAdd:   st_r <= S_ADDW;
              ModeRun: begin
                vis_r <= '0;
                cnt_r <= '0;
                fill_r <= '0;
                st_r  <= S_DSTART;
              end
              ModeClear: begin
                stored_r <= '0;
                drop_r   <= 1'b0;
                cnt_r    <= '0;
                st_r     <= S_INIT;
              end
              default: st_r <= S_IDLE;
            endcase
          end
        end
        S_ADDW: st_r <= S_ADD;
        // append edge to list of edge_from
        S_ADD: begin
          st_r <= S_IDLE;
          if ({1'b0, item_r.edge_from} >= n_r || {1'b0, item_r.edge_to} >= n_r ||
              stored_r >= LinkW'(MaxEdges)) begin
            drop_r <= 1'b1;
          end else begin
            tgt_mem[stored_r[EdgeW-1:0]]  <= item_r.edge_to;
            cost_mem[stored_r[EdgeW-1:0]] <= item_r.edge_weight;
            next_mem[stored_r[EdgeW-1:0]] <= NoEdge;
            if (head_q == NoEdge) head_mem[item_r.edge_from] <= stored_r;
            else next_mem[tail_q[EdgeW-1:0]] <= stored_r;
            tail_mem[item_r.edge_from] <= stored_r;
            stored_r <= stored_r + LinkW'(1);
          end
        end
        // DFS outer loop over start nodes
        S_DSTART: begin
          if (cnt_r >= n_r) begin
            cnt_r <= '0;
            st_r  <= S_RINIT;
          end else if (vis_r[NodeW'(cnt_r)]) begin
            cnt_r <= cnt_r + CountW'(1);
          end else begin
            vis_r[NodeW'(cnt_r)] <= 1'b1;
            u_r     <= NodeW'(cnt_r);
            depth_r <= '0;
            cnt_r   <= cnt_r + CountW'(1);
            st_r    <= S_DPUSH;
          end
        end
        // push u_r once its head has been read
        S_DPUSH: st_r <= S_DNEXT;
        S_DNEXT: begin
          snode_mem[NodeW'(depth_r)] <= u_r;
          sedge_mem[NodeW'(depth_r)] <= head_q;
          depth_r <= depth_r + CountW'(1);
          st_r    <= S_DTOPW;
        end
        S_DTOPW: st_r <= S_DTOP;
        S_DTOP: begin
          if (depth_r == '0) begin
            st_r <= S_DSTART;
          end else if (sedge_q[EdgeW]) begin
            if (fill_r < CountW'(MaxNodes)) begin
              ord_mem[NodeW'(fill_r)] <= snode_q;
              fill_r <= fill_r + CountW'(1);
            end
            depth_r <= depth_r - CountW'(1);
            st_r    <= S_DTOPW;
          end else begin
            e_r  <= sedge_q;
            st_r <= S_DEDGEW;
          end
        end
        S_DEDGEW: st_r <= S_DEDGE;
        S_DEDGE: begin
          sedge_mem[NodeW'(depth_r - CountW'(1))] <= next_q;
          if ({1'b0, tgt_q} < n_r && !vis_r[tgt_q] && depth_r < CountW'(MaxNodes)) begin
            vis_r[tgt_q] <= 1'b1;
            u_r  <= tgt_q;
            st_r <= S_DPUSH;
          end else begin
            st_r <= S_DTOPW;
          end
        end
        // clear reach flags and set the source
        S_RINIT: begin
          reach_r <= '0;
          if ({1'b0, item_r.source_node} < n_r) begin
            reach_r[item_r.source_node] <= 1'b1;
            dist_mem[item_r.source_node] <= '0;
          end
          st_r <= S_RPOPW;
        end
        S_RPOPW: st_r <= (fill_r == '0) ? S_OREAD : S_RPOP;
        S_RPOP: begin
          fill_r <= fill_r - CountW'(1);
          u_r    <= ord_q;
          st_r   <= reach_r[ord_q] ? S_RHEAD : S_RPOPW;
        end
        // head and distance of u ready next cycle
        S_RHEAD: st_r <= S_REDGE;
        S_REDGE: begin
          du_r <= dist_q;
          e_r  <= head_q;
          st_r <= head_q[EdgeW] ? S_RPOPW : S_REDGEW;
        end
        S_REDGEW: st_r <= S_RCMP;
        S_RCMP: begin
          // edge data ready; load v and weight, read dist[v] next
          v_r  <= tgt_q;
          w_r  <= cost_q;
          e_r  <= next_q;
          if ({1'b0, tgt_q} >= n_r) begin
            st_r <= next_q[EdgeW] ? S_RPOPW : S_REDGEW;
          end else begin
            st_r <= S_OWAIT;
          end
        end
        // dist of v_r read here, compared next cycle
        S_OWAIT: begin
          st_r <= S_OSEND;
        end
        // relax v_r; a self loop also moves the distance of u
        S_OSEND: begin
          if (!reach_r[v_r] || cand < dist_q) begin
            reach_r[v_r] <= 1'b1;
            dist_mem[v_r] <= cand;
            if (v_r == u_r) du_r <= cand;
          end
          st_r <= e_r[EdgeW] ? S_RPOPW : S_REDGEW;
        end
        // emit results in node order
        S_OREAD: begin
          if (!ovalid_r || out_ch.ready) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          out_r.node_index    <= NodeW'(cnt_r);
          out_r.reachable     <= reach_r[NodeW'(cnt_r)];
          out_r.distance      <= reach_r[NodeW'(cnt_r)] ? dist_q : '0;
          out_r.edges_dropped <= drop_r;
          out_r.last          <= (cnt_r + CountW'(1) == n_r);
          cnt_r <= cnt_r + CountW'(1);
          st_r  <= (cnt_r + CountW'(1) == n_r) ? S_IDLE : S_OREAD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/dsp_checker.sv
// ----------------------------------------------------------------------------
// dsp_checker: port-level checks on the shortest-path core
// Watches the result channel for handshake, zero-distance and busy rules.
// ----------------------------------------------------------------------------
module dsp_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] out_index,
  input logic out_last,
  input logic out_reach,
  input logic [23:0] out_dist,
  input logic in_ready
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index)) else $error("hold");
  // unreachable reports zero distance
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reach |-> out_dist == 24'd0) else $error("zero");
  // no new input while a non-last result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready) else $error("busy");
endmodule

bind dag_shortest_path_core dsp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_index(out_ch.data.node_index), .out_last(out_ch.data.last),
  .out_reach(out_ch.data.reachable), .out_dist(out_ch.data.distance),
  .in_ready(in_ch.ready)
);
